[design/tvmp_pkg.sv]
`timescale 1ns / 1ps

package tvmp_pkg;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_TAG     = 3'd1,
    PH_NUM     = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DOUBLE  = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_TOKEN   = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    VK_INT32  = 3'd0,
    VK_LONG   = 3'd1,
    VK_BOOL   = 3'd2,
    VK_DOUBLE = 3'd3,
    VK_STRING = 3'd4,
    VK_BYTES  = 3'd5
  } value_kind_e;

  typedef enum logic [2:0] {
    CAUSE_NONE      = 3'd0,
    CAUSE_TOO_LONG  = 3'd1,
    CAUSE_TAG_LARGE = 3'd2,
    CAUSE_BAD_TYPE  = 3'd3,
    CAUSE_TRUNCATED = 3'd4
  } cause_e;

  localparam logic [2:0] TY_POS    = 3'd0;
  localparam logic [2:0] TY_NEG    = 3'd1;
  localparam logic [2:0] TY_STRING = 3'd2;
  localparam logic [2:0] TY_BYTES  = 3'd3;
  localparam logic [2:0] TY_TRUE   = 3'd4;
  localparam logic [2:0] TY_FALSE  = 3'd5;
  localparam logic [2:0] TY_DOUBLE = 3'd6;
  localparam logic [2:0] TY_BAD    = 3'd7;

  localparam logic [4:0]  TAG_EXT     = 5'd31;
  localparam logic [63:0] INT32_LIMIT = 64'h0000_0000_7FFF_FFFF;
  localparam logic [2:0]  DBL_LAST    = 3'd7;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] field_tag;
    value_kind_e value_kind;
    logic [63:0] field_value;
    logic [7:0]  payload_data;
    logic        payload_end;
    cause_e      error_cause;
    logic        message_end;
  } result_t;

endpackage

[design/tagged_varint_message_parser_unit.sv]
`timescale 1ns / 1ps
// Channel  Handshake             Payload
// in       in_valid_i/in_ready_o  in_byte_i, last_byte_i
// out      out_valid_o/out_ready_i kind_o, field_tag_o, value_kind_o, field_value_o,
//                                 payload_data_o, payload_end_o, error_cause_o,
//                                 message_end_o
// One item is taken per cycle while no stalled result holds the input; a result
// is computed from the input register and loaded into the result register. The
// varint shift and add is combinational between those two registers.
// Reset returns the parser to the header phase and empties both registers.
// A stalled result holds the result register; the input register still takes
// one more item, and items that give no result keep moving.

module tagged_varint_message_parser_unit
  import tvmp_pkg::*;
#(
  parameter int MAX_VARINT_BYTES = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [31:0] field_tag_o,
  output logic [2:0]  value_kind_o,
  output logic [63:0] field_value_o,
  output logic [7:0]  payload_data_o,
  output logic        payload_end_o,
  output logic [2:0]  error_cause_o,
  output logic        message_end_o
);

  localparam int CntW = $clog2(MAX_VARINT_BYTES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_VARINT_BYTES);

  logic            in_valid_q;
  logic [7:0]      in_byte_q;
  logic            in_last_q;
  phase_e          phase_q, phase_d;
  logic [63:0]     acc_q, acc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]     held_tag_q, held_tag_d;
  logic [2:0]      held_type_q, held_type_d;
  logic [63:0]     left_q, left_d;
  logic [2:0]      dcnt_q, dcnt_d;
  logic            skip_q, skip_d;
  logic            out_valid_q;
  result_t         res_q;

  logic [4:0]      hdr_tag;
  logic [2:0]      hdr_type;
  logic            cont;
  logic [63:0]     shifted;
  logic [63:0]     vi_acc;
  logic [CntW-1:0] cnt_inc;
  logic            vi_long;
  logic            tag_ok;
  logic            dispatch;
  logic [2:0]      disp_type;
  logic [31:0]     disp_tag;
  logic [63:0]     dbl_acc;
  logic [31:0]     neg_low;
  value_kind_e     len_vk;
  logic            pay_end;
  logic            res_valid;
  result_t         res;
  logic            advance;

  assign hdr_tag  = in_byte_q[7:3];
  assign hdr_type = in_byte_q[2:0];
  assign cont     = in_byte_q[7];
  assign shifted  = {acc_q[56:0], in_byte_q[6:0]};
  assign vi_acc   = cont ? shifted + 64'd1 : shifted;
  assign cnt_inc  = cnt_q + CntW'(1);
  assign vi_long  = cont && (cnt_inc >= CntMax);
  assign tag_ok   = (shifted[63:32] == 32'd0);
  assign dbl_acc  = acc_q | ({56'd0, in_byte_q} << {dcnt_q, 3'b000});
  assign neg_low  = 32'd0 - shifted[31:0];
  assign len_vk   = (held_type_q == TY_BYTES) ? VK_BYTES : VK_STRING;
  assign pay_end  = (left_q == 64'd1);

  assign dispatch = (phase_q == PH_HEADER && hdr_tag != TAG_EXT) ||
                    (phase_q == PH_TAG && !vi_long && !cont && tag_ok);
  assign disp_type = (phase_q == PH_HEADER) ? hdr_type : held_type_q;
  assign disp_tag  = (phase_q == PH_HEADER) ? {27'd0, hdr_tag} : shifted[31:0];

  always_comb begin
    phase_d     = phase_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    held_tag_d  = held_tag_q;
    held_type_d = held_type_q;
    left_d      = left_q;
    dcnt_d      = dcnt_q;
    skip_d      = skip_q;
    if (!skip_q) begin
      unique case (phase_q)
        PH_HEADER: begin
          held_type_d = hdr_type;
          acc_d       = '0;
          cnt_d       = '0;
          if (hdr_tag == TAG_EXT) begin
            phase_d = PH_TAG;
          end
        end
        PH_TAG, PH_NUM, PH_LEN: begin
          acc_d = vi_acc;
          cnt_d = cnt_inc;
          if (vi_long) begin
            skip_d = !in_last_q;
          end else if (!cont) begin
            if (phase_q == PH_TAG && !tag_ok) begin
              phase_d = PH_HEADER;
              skip_d  = !in_last_q;
            end else if (phase_q == PH_NUM) begin
              phase_d = PH_HEADER;
            end else if (phase_q == PH_LEN) begin
              if (shifted == 64'd0) begin
                phase_d = PH_HEADER;
              end else begin
                left_d  = shifted;
                phase_d = PH_PAYLOAD;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          if (left_q != 64'd0) begin
            left_d = left_q - 64'd1;
          end
          if (pay_end) begin
            phase_d = PH_HEADER;
          end
        end
        PH_DOUBLE: begin
          acc_d  = dbl_acc;
          dcnt_d = dcnt_q + 3'd1;
          if (dcnt_q == DBL_LAST) begin
            phase_d = PH_HEADER;
          end
        end
        default: begin
          phase_d = PH_HEADER;
        end
      endcase
      if (dispatch) begin
        held_tag_d = disp_tag;
        acc_d      = '0;
        cnt_d      = '0;
        case (disp_type) inside
          TY_POS, TY_NEG:       phase_d = PH_NUM;
          TY_STRING, TY_BYTES:  phase_d = PH_LEN;
          TY_TRUE, TY_FALSE:    phase_d = PH_HEADER;
          TY_DOUBLE: begin
            phase_d = PH_DOUBLE;
            dcnt_d  = '0;
          end
          default: begin
            phase_d = PH_HEADER;
            skip_d  = !in_last_q;
          end
        endcase
      end
    end
    if (in_last_q) begin
      phase_d     = PH_HEADER;
      acc_d       = '0;
      cnt_d       = '0;
      held_type_d = '0;
      left_d      = '0;
      dcnt_d      = '0;
      skip_d      = 1'b0;
    end
  end

  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    if (!skip_q) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (hdr_tag == TAG_EXT && in_last_q) begin
            res_valid       = 1'b1;
            res.kind        = KIND_ERROR;
            res.error_cause = CAUSE_TRUNCATED;
          end
        end
        PH_TAG, PH_NUM, PH_LEN: begin
          if (vi_long) begin
            res_valid       = 1'b1;
            res.kind        = KIND_ERROR;
            res.error_cause = CAUSE_TOO_LONG;
          end else if (cont) begin
            if (in_last_q) begin
              res_valid       = 1'b1;
              res.kind        = KIND_ERROR;
              res.error_cause = CAUSE_TRUNCATED;
            end
          end else if (phase_q == PH_TAG) begin
            if (!tag_ok) begin
              res_valid       = 1'b1;
              res.kind        = KIND_ERROR;
              res.error_cause = CAUSE_TAG_LARGE;
            end
          end else if (phase_q == PH_NUM) begin
            res_valid     = 1'b1;
            res.field_tag = held_tag_q;
            if (held_type_q == TY_NEG) begin
              res.value_kind  = VK_INT32;
              res.field_value = {{32{neg_low[31]}}, neg_low};
            end else if (shifted < INT32_LIMIT) begin
              res.value_kind  = VK_INT32;
              res.field_value = shifted;
            end else begin
              res.value_kind  = VK_LONG;
              res.field_value = shifted;
            end
          end else begin
            res_valid = 1'b1;
            if (shifted != 64'd0 && in_last_q) begin
              res.kind        = KIND_ERROR;
              res.error_cause = CAUSE_TRUNCATED;
            end else begin
              res.field_tag   = held_tag_q;
              res.value_kind  = len_vk;
              res.field_value = shifted;
            end
          end
        end
        PH_PAYLOAD: begin
          res_valid = 1'b1;
          if (!pay_end && in_last_q) begin
            res.kind        = KIND_ERROR;
            res.error_cause = CAUSE_TRUNCATED;
          end else begin
            res.kind         = KIND_PAYLOAD;
            res.field_tag    = held_tag_q;
            res.value_kind   = len_vk;
            res.payload_data = in_byte_q;
            res.payload_end  = pay_end;
          end
        end
        PH_DOUBLE: begin
          if (dcnt_q == DBL_LAST) begin
            res_valid       = 1'b1;
            res.field_tag   = held_tag_q;
            res.value_kind  = VK_DOUBLE;
            res.field_value = dbl_acc;
          end else if (in_last_q) begin
            res_valid       = 1'b1;
            res.kind        = KIND_ERROR;
            res.error_cause = CAUSE_TRUNCATED;
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
      if (dispatch) begin
        case (disp_type) inside
          TY_TRUE, TY_FALSE: begin
            res_valid       = 1'b1;
            res.field_tag   = disp_tag;
            res.value_kind  = VK_BOOL;
            res.field_value = {63'd0, disp_type == TY_TRUE};
          end
          TY_BAD: begin
            res_valid       = 1'b1;
            res.kind        = KIND_ERROR;
            res.error_cause = CAUSE_BAD_TYPE;
          end
          default: begin
            if (in_last_q) begin
              res_valid       = 1'b1;
              res.kind        = KIND_ERROR;
              res.error_cause = CAUSE_TRUNCATED;
            end
          end
        endcase
      end
    end
    res.message_end = in_last_q;
  end

  assign advance    = in_valid_q && (!res_valid || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      acc_q       <= '0;
      cnt_q       <= '0;
      held_tag_q  <= '0;
      held_type_q <= '0;
      left_q      <= '0;
      dcnt_q      <= '0;
      skip_q      <= 1'b0;
    end else if (advance) begin
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      held_tag_q  <= held_tag_d;
      held_type_q <= held_type_d;
      left_q      <= left_d;
      dcnt_q      <= dcnt_d;
      skip_q      <= skip_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = res_q.kind;
  assign field_tag_o    = res_q.field_tag;
  assign value_kind_o   = res_q.value_kind;
  assign field_value_o  = res_q.field_value;
  assign payload_data_o = res_q.payload_data;
  assign payload_end_o  = res_q.payload_end;
  assign error_cause_o  = res_q.error_cause;
  assign message_end_o  = res_q.message_end;

endmodule

[design/tvmp_checker.sv]
`timescale 1ns / 1ps

module tvmp_checker
  import tvmp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  kind_o,
  input logic [31:0] field_tag_o,
  input logic [2:0]  value_kind_o,
  input logic [63:0] field_value_o,
  input logic [7:0]  payload_data_o,
  input logic        payload_end_o,
  input logic [2:0]  error_cause_o,
  input logic        message_end_o
);

  // A waiting result holds its kind, tag, value, payload data, error cause and message end until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) &&
      $stable(field_tag_o) && $stable(field_value_o) && $stable(payload_data_o) &&
      $stable(error_cause_o) && $stable(message_end_o))
    else $error("result changed while stalled");

  // The input side only stalls behind a result that is itself stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a stalled result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_ERROR |-> error_cause_o != CAUSE_NONE &&
      field_tag_o == 32'd0 && value_kind_o == VK_INT32 && field_value_o == 64'd0 &&
      !payload_end_o)
    else $error("error result carries field data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_PAYLOAD |-> error_cause_o == CAUSE_NONE &&
      field_value_o == 64'd0 && (value_kind_o == VK_STRING || value_kind_o == VK_BYTES))
    else $error("payload byte with wrong kind fields");

endmodule

bind tagged_varint_message_parser_unit tvmp_checker u_tvmp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .kind_o         (kind_o),
  .field_tag_o    (field_tag_o),
  .value_kind_o   (value_kind_o),
  .field_value_o  (field_value_o),
  .payload_data_o (payload_data_o),
  .payload_end_o  (payload_end_o),
  .error_cause_o  (error_cause_o),
  .message_end_o  (message_end_o)
);

[test/tagged_varint_message_parser_unit_tb.sv]
`timescale 1ns / 1ps

module tagged_varint_message_parser_unit_tb;
  import tvmp_pkg::*;

  localparam int MAX_VARINT_BYTES = 10;
  localparam int TIMEOUT_CYCLES   = 200000;
  localparam int RANDOM_ITEMS     = 650;
  localparam int HOLDOFF_AT       = 200;
  localparam int HOLDOFF_CYCLES   = 250;
  localparam int DRAIN_AT         = 450;

  localparam int VARINT_MORE = 0;
  localparam int VARINT_DONE = 1;
  localparam int VARINT_OVER = 2;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         drain;
  } body_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'd0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [31:0] field_tag;
  logic [2:0]  value_kind;
  logic [63:0] field_value;
  logic [7:0]  payload_data;
  logic        payload_end;
  logic [2:0]  error_cause;
  logic        message_end;

  tagged_varint_message_parser_unit #(
    .MAX_VARINT_BYTES(MAX_VARINT_BYTES)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .in_byte_i     (in_byte),
    .last_byte_i   (in_last),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .kind_o        (kind),
    .field_tag_o   (field_tag),
    .value_kind_o  (value_kind),
    .field_value_o (field_value),
    .payload_data_o(payload_data),
    .payload_end_o (payload_end),
    .error_cause_o (error_cause),
    .message_end_o (message_end)
  );

  always #6 clk_i = ~clk_i;

  body_item_t body_bytes_q[$];
  result_t    parse_results_q[$];
  logic [7:0] msg[$];
  int         mismatches = 0;
  int         bytes_accepted = 0;

  phase_e      parse_phase = PH_HEADER;
  logic [63:0] accum = 64'd0;
  int          vbytes = 0;
  logic [31:0] cur_tag = 32'd0;
  logic [2:0]  cur_type = 3'd0;
  logic [63:0] bytes_left = 64'd0;
  int          dbl_bytes = 0;
  bit          skipping = 1'b0;

  task automatic flag_mismatch(string what);
    $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic void emit(kind_e k, logic [31:0] tag, value_kind_e vk, logic [63:0] val,
                               logic [7:0] data, logic pend, cause_e c, logic last);
    result_t r;
    r.kind         = k;
    r.field_tag    = tag;
    r.value_kind   = vk;
    r.field_value  = val;
    r.payload_data = data;
    r.payload_end  = pend;
    r.error_cause  = c;
    r.message_end  = last;
    parse_results_q.push_back(r);
  endfunction

  function automatic void raise_error(cause_e c, logic last);
    skipping = !last;
    emit(KIND_ERROR, 32'd0, VK_INT32, 64'd0, 8'd0, 1'b0, c, last);
  endfunction

  function automatic void emit_token(value_kind_e vk, logic [63:0] val, logic last);
    emit(KIND_TOKEN, cur_tag, vk, val, 8'd0, 1'b0, CAUSE_NONE, last);
  endfunction

  function automatic void clear_parse();
    parse_phase = PH_HEADER;
    accum       = 64'd0;
    vbytes      = 0;
    cur_type    = 3'd0;
    bytes_left  = 64'd0;
    dbl_bytes   = 0;
    skipping    = 1'b0;
  endfunction

  function automatic int varint_step(logic [7:0] b);
    accum = (accum << 7) | {57'd0, b[6:0]};
    vbytes++;
    if (b[7]) begin
      accum = accum + 64'd1;
      return (vbytes >= MAX_VARINT_BYTES) ? VARINT_OVER : VARINT_MORE;
    end
    return VARINT_DONE;
  endfunction

  function automatic void start_field(logic last);
    accum  = 64'd0;
    vbytes = 0;
    case (cur_type)
      TY_POS, TY_NEG: parse_phase = PH_NUM;
      TY_STRING, TY_BYTES: parse_phase = PH_LEN;
      TY_TRUE, TY_FALSE: begin
        parse_phase = PH_HEADER;
        emit_token(VK_BOOL, (cur_type == TY_TRUE) ? 64'd1 : 64'd0, last);
        return;
      end
      TY_DOUBLE: begin
        parse_phase = PH_DOUBLE;
        dbl_bytes   = 0;
      end
      default: begin
        parse_phase = PH_HEADER;
        raise_error(CAUSE_BAD_TYPE, last);
        return;
      end
    endcase
    if (last) raise_error(CAUSE_TRUNCATED, last);
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic last);
    int          v;
    logic [31:0] neg;
    logic        fin;
    value_kind_e vk;
    if (skipping) begin
      if (last) clear_parse();
      return;
    end
    vk = (cur_type == TY_BYTES) ? VK_BYTES : VK_STRING;
    case (parse_phase)
      PH_TAG: begin
        v = varint_step(b);
        if (v == VARINT_OVER) raise_error(CAUSE_TOO_LONG, last);
        else if (v == VARINT_DONE) begin
          if (accum > 64'hFFFF_FFFF) begin
            parse_phase = PH_HEADER;
            raise_error(CAUSE_TAG_LARGE, last);
          end else begin
            cur_tag = accum[31:0];
            start_field(last);
          end
        end else if (last) raise_error(CAUSE_TRUNCATED, last);
      end
      PH_NUM: begin
        v = varint_step(b);
        if (v == VARINT_OVER) raise_error(CAUSE_TOO_LONG, last);
        else if (v == VARINT_DONE) begin
          parse_phase = PH_HEADER;
          if (cur_type == TY_NEG) begin
            neg = 32'd0 - accum[31:0];
            emit_token(VK_INT32, {{32{neg[31]}}, neg}, last);
          end else if (accum < INT32_LIMIT) emit_token(VK_INT32, accum, last);
          else emit_token(VK_LONG, accum, last);
        end else if (last) raise_error(CAUSE_TRUNCATED, last);
      end
      PH_LEN: begin
        v = varint_step(b);
        if (v == VARINT_OVER) raise_error(CAUSE_TOO_LONG, last);
        else if (v == VARINT_DONE) begin
          if (accum == 64'd0) begin
            parse_phase = PH_HEADER;
            emit_token(vk, 64'd0, last);
          end else if (last) raise_error(CAUSE_TRUNCATED, last);
          else begin
            bytes_left  = accum;
            parse_phase = PH_PAYLOAD;
            emit_token(vk, accum, last);
          end
        end else if (last) raise_error(CAUSE_TRUNCATED, last);
      end
      PH_PAYLOAD: begin
        fin = (bytes_left == 64'd1);
        if (bytes_left != 64'd0) bytes_left = bytes_left - 64'd1;
        if (!fin && last) raise_error(CAUSE_TRUNCATED, last);
        else begin
          if (fin) parse_phase = PH_HEADER;
          emit(KIND_PAYLOAD, cur_tag, vk, 64'd0, b, fin, CAUSE_NONE, last);
        end
      end
      PH_DOUBLE: begin
        accum = accum | ({56'd0, b} << (8 * (dbl_bytes % 8)));
        dbl_bytes++;
        if (dbl_bytes >= 8) begin
          parse_phase = PH_HEADER;
          emit_token(VK_DOUBLE, accum, last);
        end else if (last) raise_error(CAUSE_TRUNCATED, last);
      end
      default: begin
        cur_type = b[2:0];
        accum    = 64'd0;
        vbytes   = 0;
        if (b[7:3] == TAG_EXT) begin
          parse_phase = PH_TAG;
          if (last) raise_error(CAUSE_TRUNCATED, last);
        end else begin
          cur_tag = {27'd0, b[7:3]};
          start_field(last);
        end
      end
    endcase
    if (last) clear_parse();
  endfunction

  function automatic void add_varint(logic [63:0] n);
    logic [7:0] tmp[10];
    int len;
    len    = 0;
    tmp[0] = {1'b0, n[6:0]};
    while (n > 64'h7F) begin
      n = (n >> 7) - 64'd1;
      len++;
      tmp[len] = {1'b1, n[6:0]};
    end
    for (int i = len; i >= 0; i--) msg.push_back(tmp[i]);
  endfunction

  function automatic void add_header(logic [63:0] tag, logic [2:0] ty);
    if (tag < 64'd31) msg.push_back({tag[4:0], ty});
    else begin
      msg.push_back({TAG_EXT, ty});
      add_varint(tag);
    end
  endfunction

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return 64'h7FFF_FFFE;
      2: return INT32_LIMIT;
      3: return 64'hFFFF_FFFF_FFFF_FFFF;
      4: return {32'd0, $urandom};
      5, 6: return {$urandom, $urandom} >> $urandom_range(0, 63);
      default: return 64'($urandom_range(0, 300));
    endcase
  endfunction

  function automatic logic [63:0] pick_tag();
    case ($urandom_range(0, 19))
      0: return 64'd31;
      1: return 64'hFFFF_FFFF;
      2, 3: return {32'd0, $urandom} >> $urandom_range(0, 31);
      4: return {24'd0, 8'($urandom_range(1, 255)), $urandom};
      default: return 64'($urandom_range(0, 30));
    endcase
  endfunction

  // Returns 1 when the field leaves the message in the middle of a payload.
  function automatic bit add_field();
    logic [2:0]  ty;
    logic [63:0] len;
    ty = 3'($urandom_range(0, 7));
    add_header(pick_tag(), ty);
    case (ty)
      TY_POS, TY_NEG: add_varint(pick_value());
      TY_STRING, TY_BYTES: begin
        if ($urandom_range(0, 15) == 0) begin
          len = pick_value() | 64'd8;
          add_varint(len);
          repeat ($urandom_range(0, 3)) msg.push_back(8'($urandom));
          return 1'b1;
        end
        len = 64'($urandom_range(0, 6));
        add_varint(len);
        repeat (int'(len)) msg.push_back(8'($urandom));
      end
      TY_DOUBLE: repeat (8) msg.push_back(8'($urandom));
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic void send_message(bit drain);
    body_item_t it;
    for (int i = 0; i < msg.size(); i++) begin
      it.data  = msg[i];
      it.last  = (i == msg.size() - 1);
      it.drain = drain && (i == 0);
      body_bytes_q.push_back(it);
    end
    msg.delete();
  endfunction

  function automatic void build_random_message(bit drain);
    int cut;
    int r;
    r = $urandom_range(0, 19);
    if (r <= 14) begin
      repeat ($urandom_range(1, 4)) if (add_field()) break;
    end else if (r <= 16) begin
      repeat ($urandom_range(1, 3)) if (add_field()) break;
      cut = $urandom_range(1, msg.size());
      while (msg.size() > cut) void'(msg.pop_back());
    end else if (r == 17) begin
      msg.push_back({($urandom_range(0, 1) == 0) ? TAG_EXT : 5'($urandom_range(0, 30)),
                     3'($urandom_range(0, 3))});
      repeat (MAX_VARINT_BYTES) msg.push_back({1'b1, 7'($urandom)});
      repeat ($urandom_range(0, 3)) msg.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 8)) msg.push_back(8'($urandom));
    end
    send_message(drain);
  endfunction

  bit         byte_taken = 1'b0;
  bit         offer_pending = 1'b0;
  body_item_t offer = '{8'd0, 1'b0, 1'b0};
  int         gap_left = 0;
  int         burst_left = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (byte_taken) begin
        byte_taken    = 1'b0;
        offer_pending = 1'b0;
      end
      if (!offer_pending) begin
        if (gap_left > 0) gap_left--;
        else if (body_bytes_q.size() > 0 &&
                 !(body_bytes_q[0].drain && parse_results_q.size() != 0)) begin
          offer         = body_bytes_q.pop_front();
          offer_pending = 1'b1;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
    in_valid <= offer_pending;
    in_byte  <= offer.data;
    in_last  <= offer.last;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid && in_ready) begin
      parse_byte(in_byte, in_last);
      byte_taken = 1'b1;
      bytes_accepted++;
    end
  end

  int rx_mode = 0;
  int mode_left = 0;
  int rx_tick = 0;
  int holdoff_left = 0;
  bit holdoff_done = 1'b0;

  always @(negedge clk_i) begin
    if (!rst_ni) out_ready <= 1'b0;
    else begin
      if (!holdoff_done && bytes_accepted >= HOLDOFF_AT) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = $urandom_range(0, 2);
          mode_left = $urandom_range(16, 80);
        end
        mode_left--;
        rx_tick++;
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= (rx_tick % 4 == 0);
        endcase
      end
    end
  end

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  always @(posedge clk_i) begin : monitor
    result_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (parse_results_q.size() == 0) flag_mismatch("result with nothing expected");
      else begin
        want = parse_results_q.pop_front();
        check_field("kind", kind, want.kind);
        check_field("field_tag", field_tag, want.field_tag);
        check_field("value_kind", value_kind, want.value_kind);
        check_field("field_value", field_value, want.field_value);
        check_field("payload_data", payload_data, want.payload_data);
        check_field("payload_end", payload_end, want.payload_end);
        check_field("error_cause", error_cause, want.error_cause);
        check_field("message_end", message_end, want.message_end);
      end
    end
  end

  initial begin
    int  directed_items;
    bit  mid_drain_done;
    msg = '{8'hF4};
    send_message(1'b0);
    msg = '{8'h07};
    send_message(1'b0);
    msg = '{8'h01, 8'h01};
    send_message(1'b0);
    msg = '{8'h00, 8'h7F};
    send_message(1'b0);
    msg = '{8'h0A, 8'h02, 8'h41, 8'h42};
    send_message(1'b0);
    msg = '{8'h0B, 8'h00};
    send_message(1'b0);
    msg = '{8'hFC, 8'h7F};
    send_message(1'b0);
    msg = '{8'hFD};
    send_message(1'b0);
    msg = '{8'hFF};
    send_message(1'b0);
    msg = '{8'h00};
    send_message(1'b0);
    directed_items = body_bytes_q.size();
    build_random_message(1'b1);
    mid_drain_done = 1'b0;
    while (body_bytes_q.size() < directed_items + RANDOM_ITEMS) begin
      if (!mid_drain_done && body_bytes_q.size() >= DRAIN_AT) begin
        mid_drain_done = 1'b1;
        build_random_message(1'b1);
      end else build_random_message(1'b0);
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (body_bytes_q.size() != 0 || offer_pending) @(posedge clk_i);
    while (parse_results_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS tagged_varint_message_parser_unit");
    end else begin
      $display("FAIL tagged_varint_message_parser_unit");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 12);
    $display("FAIL tagged_varint_message_parser_unit");
    $finish;
  end

endmodule
